// ----- design/sha1_message_digest_assert.svh -----
// Assertion macros used by sha1_back.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/sha1_pkg.sv -----
package sha1_pkg;
    localparam int QDepth = 4;
    localparam int QAw = 2;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_last;
    } item_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction
endpackage

// ----- design/sha1_front.sv -----
module sha1_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     message_byte,
    input  logic           has_byte,
    input  logic           is_last,
    output logic           q_valid,
    output sha1_pkg::item_t q_item,
    input  logic           q_take
);
    sha1_pkg::item_t mem_reg [sha1_pkg::QDepth];
    logic [sha1_pkg::QAw-1:0] wr_reg, rd_reg;
    logic [sha1_pkg::QAw:0] cnt_reg;
    logic wr, rd;

    assign full = (cnt_reg == 3'(sha1_pkg::QDepth));
    // Items with no byte that are not last change nothing, so they are dropped here.
    assign wr = push && !full && (has_byte || is_last);
    assign q_valid = (cnt_reg != '0);
    assign q_item = mem_reg[rd_reg];
    assign rd = q_valid && q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wr_reg <= wr_reg + 1'b1;
            if (rd) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr ? 3'd1 : 3'd0) - (rd ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wr_reg] <= '{data: message_byte, has_byte: has_byte, is_last: is_last};
    end
endmodule

// ----- design/sha1_back.sv -----
`include "sha1_message_digest_assert.svh"
module sha1_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sha1_pkg::item_t q_item,
    output logic            q_take,
    output logic            empty,
    input  logic            pop,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LEN   = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [60:0] count_reg;
    logic [5:0]  fill_reg;
    logic [6:0]  t_reg;
    logic        final_reg;
    logic [2:0]  out_reg;
    logic        pad_reg;

    logic [31:0] w_t, w_new, f, k, tmp;
    logic [63:0] bits;
    logic        putb;
    logic [7:0]  pbyte;

    assign bits = {count_reg, 3'b000};
    assign w_new = sha1_pkg::rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign w_t = (t_reg < 7'd16) ? w_reg[0] : w_new;

    always_comb
    begin
        if (t_reg < 7'd20)
        begin
            f = (b_reg & c_reg) ^ (~b_reg & d_reg);
            k = 32'h5a827999;
        end
        else if (t_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ed9eba1;
        end
        else if (t_reg < 7'd60)
        begin
            f = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg);
            k = 32'h8f1bbcdc;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hca62c1d6;
        end
    end
    assign tmp = sha1_pkg::rotl(a_reg, 5) + f + e_reg + k + w_t;

    assign q_take = (state_reg == S_IDLE) && q_valid;
    assign putb = q_take && q_item.has_byte;
    assign pbyte = (state_reg == S_PAD) ? 8'h80 : q_item.data;
    assign empty = (state_reg != S_OUT);
    assign digest_word = h_reg[out_reg];
    assign word_index = out_reg;
    assign last_word = (out_reg == 3'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            fill_reg <= '0;
            t_reg <= '0;
            final_reg <= 1'b0;
            pad_reg <= 1'b0;
            out_reg <= '0;
            h_reg <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4};
            for (int i = 0; i < 16; i++) w_reg[i] <= '0;
            {a_reg, b_reg, c_reg, d_reg, e_reg} <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_take)
                    begin
                        if (putb)
                        begin
                            w_reg[fill_reg[5:2]] <= w_reg[fill_reg[5:2]]
                                | ({24'd0, pbyte} << (5'd8 * (5'd3 - {3'd0, fill_reg[1:0]})));
                            count_reg <= count_reg + 61'd1;
                            fill_reg <= fill_reg + 6'd1;
                        end
                        final_reg <= q_item.is_last;
                        pad_reg <= 1'b0;
                        if (putb && fill_reg == 6'd63)
                        begin
                            state_reg <= S_ROUND;
                            t_reg <= '0;
                            {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                                {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
                        end
                        else if (q_item.is_last)
                            state_reg <= S_PAD;
                    end
                end
                S_PAD:
                begin
                    w_reg[fill_reg[5:2]] <= w_reg[fill_reg[5:2]]
                        | ({24'd0, pbyte} << (5'd8 * (5'd3 - {3'd0, fill_reg[1:0]})));
                    fill_reg <= fill_reg + 6'd1;
                    pad_reg <= 1'b1;
                    if (fill_reg > 6'd55)
                    begin
                        state_reg <= S_ROUND;
                        t_reg <= '0;
                        {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                            {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
                    end
                    else
                        state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    w_reg[14] <= bits[63:32];
                    w_reg[15] <= bits[31:0];
                    fill_reg <= '0;
                    final_reg <= 1'b0;
                    state_reg <= S_ROUND;
                    t_reg <= '0;
                    pad_reg <= 1'b1;
                    {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                        {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
                end
                S_ROUND:
                begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_t;
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= sha1_pkg::rotl(b_reg, 30);
                    b_reg <= a_reg;
                    a_reg <= tmp;
                    t_reg <= t_reg + 7'd1;
                    if (t_reg == 7'd79) state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    for (int i = 0; i < 16; i++) w_reg[i] <= '0;
                    fill_reg <= '0;
                    if (final_reg && !pad_reg)
                        state_reg <= S_PAD;
                    else if (final_reg)
                        state_reg <= S_LEN;
                    else if (pad_reg)
                    begin
                        state_reg <= S_OUT;
                        out_reg <= '0;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    if (pop)
                    begin
                        out_reg <= out_reg + 3'd1;
                        if (out_reg == 3'd4)
                        begin
                            state_reg <= S_IDLE;
                            h_reg <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2,
                                       sha1_pkg::H3, sha1_pkg::H4};
                            count_reg <= '0;
                            fill_reg <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SHA_ASSERT_IMPL(a_out_range, clk, rst_n, !empty, out_reg <= 3'd4)
    `SHA_ASSERT_IMPL(a_take_idle, clk, rst_n, q_take, empty)
    `SHA_ASSERT_NEXT(a_round_end, clk, rst_n, state_reg == S_ROUND && t_reg == 7'd79,
        state_reg == S_ADD)
endmodule

// ----- design/sha1_message_digest.sv -----
// SHA-1 digest of a byte message, one byte per item.
// Input queue side: drive message_byte, has_byte and is_last with push; an
// item is taken at a clock edge with push high and full low. Mark the last
// item with is_last; has_byte low on it ends the message without a byte.
// Result queue side: while empty is low, digest_word, word_index and
// last_word show the next digest word, taken with pop. Five words follow
// each last item, word 0 most significant, last_word high on word 4.
// A four-entry item queue parts the input from the compression engine.
// The engine takes bytes from the queue while idle; each full 64-byte
// block then runs its rounds and update in the single shared round unit,
// and no item is taken meanwhile. After the last item the engine adds the
// pad byte and the length, with a second block when padding needs one or
// the last byte fills a block. The digest words can then be taken one per
// cycle while pop stays high. A stalled result holds the engine; the input
// queue keeps taking items until it is full. Reset clears the queue and
// returns the chaining state to the standard initial values.
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  message_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    logic q_valid, q_take;
    sha1_pkg::item_t q_item;

    sha1_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .message_byte(message_byte), .has_byte(has_byte), .is_last(is_last),
        .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
    );

    sha1_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );
endmodule

// ----- sim/sha1_message_digest_tb.sv -----
module sha1_message_digest_tb;
    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  message_byte;
    logic        has_byte;
    logic        is_last;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_out_t;

    digest_out_t expected_words[$];
    int          error_count;

    logic [31:0] chain[5];
    logic [31:0] sched[16];
    logic [60:0] msg_bytes;
    int          fill;

    sha1_message_digest uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .message_byte(message_byte), .has_byte(has_byte), .is_last(is_last),
        .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_chain();
        chain[0] = sha1_pkg::H0;
        chain[1] = sha1_pkg::H1;
        chain[2] = sha1_pkg::H2;
        chain[3] = sha1_pkg::H3;
        chain[4] = sha1_pkg::H4;
        msg_bytes = '0;
        fill = 0;
        for (int i = 0; i < 16; i++)
        begin
            sched[i] = '0;
        end
    endtask

    task automatic compress();
        logic [31:0] v[5];
        logic [31:0] f;
        logic [31:0] k;
        logic [31:0] tmp;
        for (int i = 0; i < 5; i++)
        begin
            v[i] = chain[i];
        end
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                sched[t & 15] = rol32(sched[(t - 3) & 15] ^ sched[(t - 8) & 15]
                    ^ sched[(t - 14) & 15] ^ sched[t & 15], 1);
            end
            if (t < 20)
            begin
                f = (v[1] & v[2]) ^ (~v[1] & v[3]);
                k = 32'h5a827999;
            end
            else if (t < 40)
            begin
                f = v[1] ^ v[2] ^ v[3];
                k = 32'h6ed9eba1;
            end
            else if (t < 60)
            begin
                f = (v[1] & v[2]) ^ (v[1] & v[3]) ^ (v[2] & v[3]);
                k = 32'h8f1bbcdc;
            end
            else
            begin
                f = v[1] ^ v[2] ^ v[3];
                k = 32'hca62c1d6;
            end
            tmp = rol32(v[0], 5) + f + v[4] + k + sched[t & 15];
            v[4] = v[3];
            v[3] = v[2];
            v[2] = rol32(v[1], 30);
            v[1] = v[0];
            v[0] = tmp;
        end
        for (int i = 0; i < 5; i++)
        begin
            chain[i] = chain[i] + v[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            sched[i] = '0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        sched[fill / 4] = sched[fill / 4] | ({24'h0, b} << (8 * (3 - fill % 4)));
        fill++;
        if (fill >= 64)
        begin
            compress();
            fill = 0;
        end
    endtask

    task automatic predict_digest(input logic [7:0] b, input logic hb, input logic lst);
        logic [63:0] bits;
        digest_out_t d;
        if (hb)
        begin
            absorb_byte(b);
            msg_bytes = msg_bytes + 1'b1;
        end
        if (lst)
        begin
            bits = {msg_bytes, 3'b000};
            absorb_byte(8'h80);
            if (fill > 56)
            begin
                compress();
                fill = 0;
            end
            sched[14] = bits[63:32];
            sched[15] = bits[31:0];
            compress();
            for (int i = 0; i < 5; i++)
            begin
                d.word = chain[i];
                d.index = 3'(i);
                d.last = (i == 4);
                expected_words = {expected_words, d};
            end
            restart_chain();
        end
    endtask

    task automatic report(input string what, input logic [31:0] got,
        input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap)
            begin
                @(posedge clk);
            end
        end
        push <= 1'b1;
        message_byte <= b;
        has_byte <= hb;
        is_last <= lst;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        predict_digest(b, hb, lst);
    endtask

    task automatic send_message(input int len, input bit empty_last);
        for (int i = 0; i < len; i++)
        begin
            send_item(8'($urandom), 1'b1, !empty_last && i == len - 1);
        end
        if (empty_last || len == 0)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_edge_messages();
        send_message(0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b1);
        send_message(3, 1'b0);
        wait_drained();
    endtask

    task automatic test_padding_boundaries();
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < 16)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130)
                : $urandom_range(0, 20);
            send_message(len, $urandom_range(0, 3) == 0);
            sent += len + 1;
        end
        wait_drained();
    endtask

    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall)
                begin
                    @(posedge clk);
                end
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
            begin
                @(posedge clk);
            end
            if (expected_words.size() == 0)
            begin
                report("unexpected word", digest_word, 32'h0);
            end
            else
            begin
                if (digest_word !== expected_words[0].word)
                begin
                    report("digest_word", digest_word, expected_words[0].word);
                end
                if (word_index !== expected_words[0].index)
                begin
                    report("word_index", 32'(word_index), 32'(expected_words[0].index));
                end
                if (last_word !== expected_words[0].last)
                begin
                    report("last_word", 32'(last_word), 32'(expected_words[0].last));
                end
                void'(expected_words.pop_front());
            end
        end
    end

    initial
    begin
        #20000000;
        $display("** sha1_message_digest: FAILED **");
        $finish;
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        push = 1'b0;
        message_byte = '0;
        has_byte = 1'b0;
        is_last = 1'b0;
        restart_chain();
        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_messages();
        test_padding_boundaries();
        test_random_messages();
        repeat (200)
        begin
            @(posedge clk);
        end
        if (error_count == 0 && expected_words.size() == 0)
        begin
            $display("** sha1_message_digest: PASSED **");
        end
        else
        begin
            $display("** sha1_message_digest: FAILED **");
        end
        $finish;
    end
endmodule
